// ----- hdl/irc_pkg.sv -----
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types and constants of the interval room counter.
// ----------------------------------------------------------------------------
package irc_pkg;

  localparam int unsigned TIME_W  = 31;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT_RD,
    S_ROOT_CHK,
    S_LAST,
    S_SD_L,
    S_SD_R,
    S_SD_RCMP,
    S_SD_MOVE,
    S_PUSH,
    S_SU,
    S_SU_CMP,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] rooms_in_use;
    logic [COUNT_W-1:0] max_rooms;
    logic               order_error;
    logic               heap_overflow;
    logic               set_done;
  } result_t;

endpackage

// ----- hdl/irc_heap_mem.sv -----
// ----------------------------------------------------------------------------
// irc_heap_mem
// Heap storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module irc_heap_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned W     = 31
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [W-1:0]  rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [W-1:0]  wr_data_i
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- hdl/irc_seq.sv -----
// ----------------------------------------------------------------------------
// irc_seq
// Heap sequencer: pops expired end times, pushes the new one unless the heap
// is full, and tracks the occupancy and peak of the current set.
// ----------------------------------------------------------------------------
module irc_seq #(
  parameter int unsigned HEAP_DEPTH = 256,
  parameter int unsigned AW         = 8,
  parameter int unsigned CW         = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [irc_pkg::TIME_W-1:0] start_time_i,
  input  logic [irc_pkg::TIME_W-1:0] end_time_i,
  input  logic                       last_interval_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output irc_pkg::result_t           res_o,
  output logic                       rd_en_o,
  output logic [AW-1:0]              rd_addr_o,
  input  logic [irc_pkg::TIME_W-1:0] rd_data_i,
  output logic                       wr_en_o,
  output logic [AW-1:0]              wr_addr_o,
  output logic [irc_pkg::TIME_W-1:0] wr_data_o
);

  localparam int unsigned LW = AW + 1;

  irc_pkg::seq_state_e state_q, state_d;

  logic [irc_pkg::TIME_W-1:0] start_q, start_d;
  logic [irc_pkg::TIME_W-1:0] end_q, end_d;
  logic [irc_pkg::TIME_W-1:0] prev_q, prev_d;
  logic [irc_pkg::TIME_W-1:0] cur_q, cur_d;
  logic [irc_pkg::TIME_W-1:0] child_q, child_d;
  logic [AW-1:0]              child_idx_q, child_idx_d;
  logic [AW-1:0]              pos_q, pos_d;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              peak_q, peak_d;
  logic                       last_q, last_d;
  logic                       misorder_q, misorder_d;
  logic                       ovf_q, ovf_d;

  logic          accept;
  logic [LW-1:0] l_idx;
  logic [LW-1:0] r_idx;
  logic [LW-1:0] count_ext;
  logic          full;
  logic [CW-1:0] peak_new;
  logic [AW-1:0] parent_idx;
  logic [CW-1:0] count_dec;

  assign accept     = in_valid_i && in_ready_o;
  assign l_idx      = {pos_q, 1'b1};
  assign r_idx      = l_idx + LW'(1);
  assign count_ext  = LW'(count_q);
  assign full       = (count_q == CW'(HEAP_DEPTH));
  assign peak_new   = (count_q > peak_q) ? count_q : peak_q;
  assign parent_idx = AW'((pos_q - AW'(1)) >> 1);
  assign count_dec  = count_q - CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      irc_pkg::S_IDLE:     if (accept) state_d = irc_pkg::S_ROOT_RD;
      irc_pkg::S_ROOT_RD:  state_d = (count_q == '0) ? irc_pkg::S_PUSH : irc_pkg::S_ROOT_CHK;
      irc_pkg::S_ROOT_CHK: begin
        if (rd_data_i > start_q) begin
          state_d = irc_pkg::S_PUSH;
        end else if (count_q == CW'(1)) begin
          state_d = irc_pkg::S_ROOT_RD;
        end else begin
          state_d = irc_pkg::S_LAST;
        end
      end
      irc_pkg::S_LAST:     state_d = irc_pkg::S_SD_L;
      irc_pkg::S_SD_L:     state_d = (l_idx < count_ext) ? irc_pkg::S_SD_R : irc_pkg::S_ROOT_RD;
      irc_pkg::S_SD_R:     state_d = (r_idx < count_ext) ? irc_pkg::S_SD_RCMP
                                                         : irc_pkg::S_SD_MOVE;
      irc_pkg::S_SD_RCMP:  state_d = irc_pkg::S_SD_MOVE;
      irc_pkg::S_SD_MOVE:  state_d = (cur_q <= child_q) ? irc_pkg::S_ROOT_RD : irc_pkg::S_SD_L;
      irc_pkg::S_PUSH:     state_d = full ? irc_pkg::S_DONE : irc_pkg::S_SU;
      irc_pkg::S_SU:       state_d = (pos_q == '0) ? irc_pkg::S_DONE : irc_pkg::S_SU_CMP;
      irc_pkg::S_SU_CMP:   state_d = (rd_data_i <= cur_q) ? irc_pkg::S_DONE : irc_pkg::S_SU;
      irc_pkg::S_DONE:     if (res_ready_i) state_d = irc_pkg::S_IDLE;
      default:             state_d = irc_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    start_d     = start_q;
    end_d       = end_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    child_d     = child_q;
    child_idx_d = child_idx_q;
    pos_d       = pos_q;
    count_d     = count_q;
    peak_d      = peak_q;
    last_d      = last_q;
    misorder_d  = misorder_q;
    ovf_d       = ovf_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = '0;
    wr_en_o     = 1'b0;
    wr_addr_o   = pos_q;
    wr_data_o   = cur_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      irc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          start_d    = start_time_i;
          end_d      = end_time_i;
          last_d     = last_interval_i;
          misorder_d = (start_time_i < prev_q);
          prev_d     = start_time_i;
          ovf_d      = 1'b0;
        end
      end
      irc_pkg::S_ROOT_RD: begin
        rd_en_o = (count_q != '0);
      end
      irc_pkg::S_ROOT_CHK: begin
        if (rd_data_i <= start_q) begin
          count_d   = count_dec;
          rd_en_o   = (count_q != CW'(1));
          rd_addr_o = AW'(count_dec);
        end
      end
      irc_pkg::S_LAST: begin
        cur_d = rd_data_i;
        pos_d = '0;
      end
      irc_pkg::S_SD_L: begin
        if (l_idx < count_ext) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(l_idx);
        end else begin
          wr_en_o = 1'b1;
        end
      end
      irc_pkg::S_SD_R: begin
        child_d     = rd_data_i;
        child_idx_d = AW'(l_idx);
        if (r_idx < count_ext) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(r_idx);
        end
      end
      irc_pkg::S_SD_RCMP: begin
        if (rd_data_i < child_q) begin
          child_d     = rd_data_i;
          child_idx_d = AW'(r_idx);
        end
      end
      irc_pkg::S_SD_MOVE: begin
        wr_en_o = 1'b1;
        if (cur_q > child_q) begin
          wr_data_o = child_q;
          pos_d     = child_idx_q;
        end
      end
      irc_pkg::S_PUSH: begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          pos_d   = AW'(count_q);
          count_d = count_q + CW'(1);
          cur_d   = end_q;
        end
      end
      irc_pkg::S_SU: begin
        if (pos_q == '0) begin
          wr_en_o = 1'b1;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = parent_idx;
        end
      end
      irc_pkg::S_SU_CMP: begin
        wr_en_o = 1'b1;
        if (rd_data_i > cur_q) begin
          wr_data_o = rd_data_i;
          pos_d     = parent_idx;
        end
      end
      irc_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          peak_d = peak_new;
          if (last_q) begin
            count_d = '0;
            peak_d  = '0;
            prev_d  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.rooms_in_use  = irc_pkg::COUNT_W'(count_q);
  assign res_o.max_rooms     = irc_pkg::COUNT_W'(peak_new);
  assign res_o.order_error   = misorder_q;
  assign res_o.heap_overflow = ovf_q;
  assign res_o.set_done      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= irc_pkg::S_IDLE;
      count_q <= '0;
      peak_q  <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    end_q       <= end_d;
    cur_q       <= cur_d;
    child_q     <= child_d;
    child_idx_q <= child_idx_d;
    pos_q       <= pos_d;
    last_q      <= last_d;
    misorder_q  <= misorder_d;
    ovf_q       <= ovf_d;
  end

endmodule

// ----- hdl/interval_room_counter_top.sv -----
// ----------------------------------------------------------------------------
// interval_room_counter_top
// Interval partitioning: counts rooms in use with a min-heap of end times.
// ----------------------------------------------------------------------------
// Intervals of one set must arrive in ascending start order; a word whose
// start is below the previous one is still handled and flagged. One word is
// worked on at a time. Each expired end time is removed from the heap with a
// sift down, and the new end, if the heap has room, is added with a sift up;
// these loops over the heap memory set how long an item takes. The result
// sits in an output register, so the next word is taken while a result
// waits. The word flagged last clears the set state after its result.
module interval_room_counter_top #(
  parameter int unsigned HEAP_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [irc_pkg::TIME_W-1:0] start_time_i,
  input  logic [irc_pkg::TIME_W-1:0] end_time_i,
  input  logic                       last_interval_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [irc_pkg::COUNT_W-1:0] rooms_in_use_o,
  output logic [irc_pkg::COUNT_W-1:0] max_rooms_o,
  output logic                       order_error_o,
  output logic                       heap_overflow_o,
  output logic                       set_done_o
);

  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

  logic                       res_valid;
  logic                       res_ready;
  irc_pkg::result_t           res;
  irc_pkg::result_t           out_q;
  logic                       out_valid_q;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [irc_pkg::TIME_W-1:0] rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [irc_pkg::TIME_W-1:0] wr_data;

  assign res_ready = !out_valid_q || out_ready_i;

  irc_seq #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_time_i    (start_time_i),
    .end_time_i      (end_time_i),
    .last_interval_i (last_interval_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  irc_heap_mem #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW),
    .W     (irc_pkg::TIME_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rooms_in_use_o  = out_q.rooms_in_use;
  assign max_rooms_o     = out_q.max_rooms;
  assign order_error_o   = out_q.order_error;
  assign heap_overflow_o = out_q.heap_overflow;
  assign set_done_o      = out_q.set_done;

endmodule

// ----- hdl/irc_checker.sv -----
// ----------------------------------------------------------------------------
// irc_bind_checks
// Port level checks of the interval room counter, bound to the top level.
// ----------------------------------------------------------------------------
module irc_bind_checks (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [irc_pkg::COUNT_W-1:0] rooms_in_use_o,
  input logic [irc_pkg::COUNT_W-1:0] max_rooms_o,
  input logic                        heap_overflow_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rooms_in_use_o)
      && $stable(max_rooms_o))
    else $error("result word changed while stalled");

  // peak never below current occupancy
  a_peak_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> max_rooms_o >= rooms_in_use_o)
    else $error("max_rooms below rooms_in_use");

  // a dropped insert means the heap sits at its peak
  a_ovf_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && heap_overflow_o |-> max_rooms_o == rooms_in_use_o)
    else $error("overflow without full occupancy");

  // one word at a time
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

endmodule

bind interval_room_counter_top irc_bind_checks u_irc_bind_checks (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .rooms_in_use_o  (rooms_in_use_o),
  .max_rooms_o     (max_rooms_o),
  .heap_overflow_o (heap_overflow_o)
);

// ----- sim/irc_checker.sv -----
// ----------------------------------------------------------------------------
// irc_checker
// Watches both channels of the interval room counter and checks each result.
// ----------------------------------------------------------------------------
// Every accepted interval is placed in a plain list of open end times: ends at
// or below the new start are dropped, the new end is added unless the list
// already holds HEAP_DEPTH entries, and the set peak is tracked. The result
// this gives is queued and compared field by field with the next result word.
// Mismatches are printed one per line and counted for the top.
module irc_checker #(
  parameter int unsigned HEAP_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [irc_pkg::TIME_W-1:0]  start_time_i,
  input  logic [irc_pkg::TIME_W-1:0]  end_time_i,
  input  logic                        last_interval_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [irc_pkg::COUNT_W-1:0] rooms_in_use_i,
  input  logic [irc_pkg::COUNT_W-1:0] max_rooms_i,
  input  logic                        order_error_i,
  input  logic                        heap_overflow_i,
  input  logic                        set_done_i,
  output int unsigned                 errors_o,
  output int unsigned                 pending_o
);

  irc_pkg::result_t           expected_results[$];
  logic [irc_pkg::TIME_W-1:0] open_ends[$];
  int unsigned                peak_rooms;
  logic [irc_pkg::TIME_W-1:0] prior_start;
  int unsigned                mismatch_count = 0;
  int unsigned                pending_count  = 0;
  int unsigned                result_index   = 0;

  assign errors_o  = mismatch_count;
  assign pending_o = pending_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] irc_checker: result %0d: %s", $time, result_index, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    irc_pkg::result_t           want;
    logic [irc_pkg::TIME_W-1:0] still_open[$];
    int unsigned                rooms;
    if (!rst_ni) begin
      expected_results.delete();
      open_ends.delete();
      peak_rooms    = 0;
      prior_start   = '0;
      pending_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with no interval waiting for it");
        end else begin
          want = expected_results.pop_front();
          if (rooms_in_use_i !== want.rooms_in_use) begin
            report_mismatch($sformatf("rooms_in_use %0d, expected %0d",
                                      rooms_in_use_i, want.rooms_in_use));
          end
          if (max_rooms_i !== want.max_rooms) begin
            report_mismatch($sformatf("max_rooms %0d, expected %0d",
                                      max_rooms_i, want.max_rooms));
          end
          if (order_error_i !== want.order_error) begin
            report_mismatch($sformatf("order_error %b, expected %b",
                                      order_error_i, want.order_error));
          end
          if (heap_overflow_i !== want.heap_overflow) begin
            report_mismatch($sformatf("heap_overflow %b, expected %b",
                                      heap_overflow_i, want.heap_overflow));
          end
          if (set_done_i !== want.set_done) begin
            report_mismatch($sformatf("set_done %b, expected %b",
                                      set_done_i, want.set_done));
          end
        end
        result_index++;
      end
      if (in_valid_i && in_ready_i) begin
        want.order_error = (start_time_i < prior_start);
        prior_start = start_time_i;
        // rooms whose end is at or before the new start are free again
        still_open.delete();
        foreach (open_ends[i]) begin
          if (open_ends[i] > start_time_i) begin
            still_open.push_back(open_ends[i]);
          end
        end
        open_ends = still_open;
        want.heap_overflow = (open_ends.size() >= HEAP_DEPTH);
        if (!want.heap_overflow) begin
          open_ends.push_back(end_time_i);
        end
        rooms = open_ends.size();
        if (rooms > peak_rooms) begin
          peak_rooms = rooms;
        end
        want.rooms_in_use = irc_pkg::COUNT_W'(rooms);
        want.max_rooms    = irc_pkg::COUNT_W'(peak_rooms);
        want.set_done     = last_interval_i;
        expected_results.push_back(want);
        if (last_interval_i) begin
          open_ends.delete();
          peak_rooms  = 0;
          prior_start = '0;
        end
      end
      pending_count = expected_results.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Random and directed stimulus for the interval room counter.
// ----------------------------------------------------------------------------
// A short directed run covers time extremes, ends equal to or below the start
// and out of order starts. Random sets follow: mostly sorted sets of
// overlapping intervals, some sets that fill the heap past its depth and then
// free every room at once, and single noise words. Both sides idle at random;
// the result side holds off for long stretches so that the block stalls. An
// attached checker predicts and compares every result word.
module testbench;

  localparam int unsigned                HEAP_DEPTH   = 256;
  localparam int unsigned                WORD_TARGET  = 1600;
  localparam int unsigned                IDLE_LIMIT   = 50000;
  localparam int unsigned                HOLD_CYCLES  = 400;
  localparam int unsigned                DRAIN_CYCLES = 200;
  localparam logic [irc_pkg::TIME_W-1:0] TIME_MAX     = '1;

  logic                        clk           = 1'b0;
  logic                        rst_n         = 1'b0;
  logic                        in_valid      = 1'b0;
  logic                        in_ready;
  logic [irc_pkg::TIME_W-1:0]  start_time    = '0;
  logic [irc_pkg::TIME_W-1:0]  end_time      = '0;
  logic                        last_interval = 1'b0;
  logic                        out_valid;
  logic                        out_ready     = 1'b0;
  logic [irc_pkg::COUNT_W-1:0] rooms_in_use;
  logic [irc_pkg::COUNT_W-1:0] max_rooms;
  logic                        order_error;
  logic                        heap_overflow;
  logic                        set_done;

  int unsigned errors;
  int unsigned pending;
  int unsigned words_sent    = 0;
  int unsigned sets_sent     = 0;
  int unsigned fill_sets     = 0;
  bit          hold_off_req  = 1'b0;
  bit          steady_sender = 1'b0;
  bit          mid_hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  interval_room_counter_top #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .start_time_i   (start_time),
    .end_time_i     (end_time),
    .last_interval_i(last_interval),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .rooms_in_use_o (rooms_in_use),
    .max_rooms_o    (max_rooms),
    .order_error_o  (order_error),
    .heap_overflow_o(heap_overflow),
    .set_done_o     (set_done)
  );

  irc_checker #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .start_time_i   (start_time),
    .end_time_i     (end_time),
    .last_interval_i(last_interval),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .rooms_in_use_i (rooms_in_use),
    .max_rooms_i    (max_rooms),
    .order_error_i  (order_error),
    .heap_overflow_i(heap_overflow),
    .set_done_i     (set_done),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_sender || r < 60) begin
      return 0;
    end
    if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [irc_pkg::TIME_W-1:0] s,
                           input logic [irc_pkg::TIME_W-1:0] e,
                           input logic l);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    start_time    <= s;
    end_time      <= e;
    last_interval <= l;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (l) begin
      sets_sent++;
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_sorted_set();
    int unsigned                len;
    int unsigned                r;
    logic [irc_pkg::TIME_W-1:0] s;
    logic [irc_pkg::TIME_W-1:0] e;
    len = $urandom_range(1, 24);
    s   = irc_pkg::TIME_W'($urandom);
    for (int unsigned k = 0; k < len; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        s = s - irc_pkg::TIME_W'($urandom_range(1, 20));
      end else if (r > 2) begin
        s = s + irc_pkg::TIME_W'($urandom_range(1, 12));
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
        e = s;
      end else if (r == 1) begin
        e = s - irc_pkg::TIME_W'($urandom_range(1, 30));
      end else begin
        e = s + irc_pkg::TIME_W'($urandom_range(1, 40));
      end
      send_word(s, e, k == len - 1);
    end
  endtask

  task automatic send_fill_set();
    int unsigned                len;
    logic [irc_pkg::TIME_W-1:0] s;
    s   = irc_pkg::TIME_W'($urandom_range(0, 32'h3FFF_FFFF));
    len = HEAP_DEPTH + $urandom_range(1, 6);
    for (int unsigned k = 0; k < len; k++) begin
      send_word(s, s + irc_pkg::TIME_W'(1)
                     + irc_pkg::TIME_W'($urandom_range(0, 32'h3FFF_FFFE)), 1'b0);
    end
    // every open room has ended by the latest start
    send_word(TIME_MAX, irc_pkg::TIME_W'($urandom), 1'b1);
    fill_sets++;
  endtask

  initial begin : receiver
    int unsigned run;
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = $urandom_range(0, 99);
      if (gap < 50) begin
        gap = 0;
      end else if (gap < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(10, 60);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no word moved for %0d cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned kind;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_word('0, '0, 1'b0);
    send_word('0, TIME_MAX, 1'b0);
    send_word(31'd5, 31'd3, 1'b0);
    send_word(31'd3, 31'd10, 1'b0);
    send_word(TIME_MAX, TIME_MAX, 1'b1);
    send_word(TIME_MAX, '0, 1'b1);
    send_word(31'h2AAA_AAAA, 31'h5555_5555, 1'b0);
    send_word(31'h5555_5555, 31'h2AAA_AAAA, 1'b1);
    send_word(31'd10, 31'd100, 1'b0);
    send_word(31'd20, 31'd90, 1'b0);
    send_word(31'd30, 31'd80, 1'b0);
    send_word(31'd40, 31'd70, 1'b0);
    send_word(31'd80, 31'd85, 1'b0);
    send_word(31'd100, 31'd110, 1'b1);
    send_word(31'd7, 31'd8, 1'b0);
    send_word(31'd6, 31'd6, 1'b1);
    send_word('0, TIME_MAX, 1'b1);
    wait_for_results();

    // heap fills while the result side holds off
    hold_off_req  = 1'b1;
    steady_sender = 1'b1;
    send_fill_set();

    while (words_sent < WORD_TARGET) begin
      steady_sender = ($urandom_range(0, 6) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 2) begin
        wait_for_results();
        send_fill_set();
      end else if (kind < 86) begin
        send_sorted_set();
      end else begin
        send_word(irc_pkg::TIME_W'($urandom), irc_pkg::TIME_W'($urandom),
                  $urandom_range(0, 3) != 0);
      end
      if (!mid_hold_done && words_sent >= WORD_TARGET / 2) begin
        hold_off_req  = 1'b1;
        mid_hold_done = 1'b1;
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d intervals in %0d sets, %0d sets pushed past the %0d room heap",
             words_sent, sets_sent, fill_sets, HEAP_DEPTH);
    $display("random gaps on both sides, two long result hold-offs, %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
